/* rtl/core/jsu_pkg.sv */
// Shared types and constants of the JSON string unescape block.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   localparam logic REG_OUT_LIMIT = 1'b0;
   localparam logic [15:0] OUT_LIMIT_RESET = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [1:0]  num_bytes;
      logic        status;
      logic        last;
      logic [15:0] base_count;
   } entry_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        error;
      logic        run_last;
      logic        string_end;
      logic [15:0] byte_count;
   } beat_type;

endpackage

/* rtl/core/jsu_front.sv */
// Front end: decodes escapes per input byte and builds queue entries.
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               queue_full,
   input  logic [7:0]         in_byte,
   input  logic               last_byte,
   input  logic [15:0]        out_limit,
   output logic               entry_valid,
   output jsu_pkg::entry_type entry
);

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_HEX0   = 3'd2;
   localparam logic [2:0] MODE_HEX1   = 3'd3;
   localparam logic [2:0] MODE_HEX2   = 3'd4;
   localparam logic [2:0] MODE_HEX3   = 3'd5;
   localparam logic [2:0] MODE_DROP   = 3'd6;

   logic [2:0]  mode_ff, mode_in, mode_nx;
   logic [15:0] hex_ff, hex_in, hex_nx;
   logic [15:0] count_ff, count_in;
   logic        accept;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [1:0]  nb;
   logic [7:0]  b0, b1, b2;
   logic        err;
   logic        drop;
   logic [16:0] sum;

   assign accept = push && !queue_full;

   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      mode_nx = mode_ff;
      hex_nx = hex_ff;
      nb = 2'd0;
      b0 = 8'd0;
      b1 = 8'd0;
      b2 = 8'd0;
      err = 1'b0;
      case (mode_ff)
         MODE_NORMAL: begin
            if (in_byte == jsu_pkg::CH_BSLASH) begin
               mode_nx = MODE_ESC;
            end else begin
               nb = 2'd1;
               b0 = in_byte;
            end
         end
         MODE_ESC: begin
            mode_nx = MODE_NORMAL;
            nb = 2'd1;
            case (in_byte)
               jsu_pkg::CH_QUOTE:  b0 = in_byte;
               jsu_pkg::CH_BSLASH: b0 = in_byte;
               jsu_pkg::CH_SLASH:  b0 = in_byte;
               jsu_pkg::CH_B:      b0 = jsu_pkg::CTL_BS;
               jsu_pkg::CH_F:      b0 = jsu_pkg::CTL_FF;
               jsu_pkg::CH_N:      b0 = jsu_pkg::CTL_LF;
               jsu_pkg::CH_R:      b0 = jsu_pkg::CTL_CR;
               jsu_pkg::CH_T:      b0 = jsu_pkg::CTL_HT;
               jsu_pkg::CH_U: begin
                  nb = 2'd0;
                  mode_nx = MODE_HEX0;
                  hex_nx = 16'd0;
               end
               default: begin
                  nb = 2'd0;
                  err = 1'b1;
               end
            endcase
         end
         MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
            if (!hex_ok) begin
               err = 1'b1;
            end else begin
               hex_nx = {hex_ff[11:0], hex_val};
               if (mode_ff == MODE_HEX3) begin
                  mode_nx = MODE_NORMAL;
                  if (hex_nx < 16'h0080) begin
                     nb = 2'd1;
                     b0 = hex_nx[7:0];
                  end else if (hex_nx < 16'h0800) begin
                     nb = 2'd2;
                     b0 = {3'b110, hex_nx[10:6]};
                     b1 = {2'b10, hex_nx[5:0]};
                  end else begin
                     nb = 2'd3;
                     b0 = {4'b1110, hex_nx[15:12]};
                     b1 = {2'b10, hex_nx[11:6]};
                     b2 = {2'b10, hex_nx[5:0]};
                  end
               end else begin
                  mode_nx = 3'(mode_ff + 3'd1);
               end
            end
         end
         default: begin
            mode_nx = MODE_DROP;
         end
      endcase

      sum = {1'b0, count_ff} + {15'd0, nb};
      if (!err && nb != 2'd0 && sum > {1'b0, out_limit}) begin
         err = 1'b1;
      end
      if (err) begin
         nb = 2'd0;
      end
      if (!err && last_byte && mode_nx != MODE_NORMAL && mode_nx != MODE_DROP) begin
         err = 1'b1;
      end
      if (err) begin
         mode_nx = MODE_DROP;
      end
      drop = (mode_nx == MODE_DROP);
   end

   always_comb begin
      entry.byte0 = drop ? 8'd0 : b0;
      entry.byte1 = b1;
      entry.byte2 = b2;
      entry.num_bytes = nb;
      entry.status = drop;
      entry.last = last_byte;
      entry.base_count = count_ff;
      entry_valid = accept && (drop ? last_byte : (nb != 2'd0));
   end

   always_comb begin
      mode_in = mode_ff;
      hex_in = hex_ff;
      count_in = count_ff;
      if (accept) begin
         if (last_byte) begin
            mode_in = MODE_NORMAL;
            hex_in = 16'd0;
            count_in = 16'd0;
         end else begin
            mode_in = mode_nx;
            hex_in = hex_nx;
            count_in = 16'(count_ff + {14'd0, nb});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         hex_ff <= 16'd0;
         count_ff <= 16'd0;
      end else begin
         mode_ff <= mode_in;
         hex_ff <= hex_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/jsu_queue.sv */
// Short entry queue between the decode front end and the beat back end.
module jsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  jsu_pkg::entry_type wr_entry,
   input  logic               rd_en,
   output jsu_pkg::entry_type rd_entry,
   output logic               full,
   output logic               empty
);

   jsu_pkg::entry_type slots_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full = (count_ff == jsu_pkg::QUEUE_CNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? jsu_pkg::QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? jsu_pkg::QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = jsu_pkg::QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = jsu_pkg::QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/core/jsu_back.sv */
// Back end: expands each queue entry into its result beats.
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::entry_type head,
   input  logic               head_empty,
   input  logic               pop,
   output logic               head_pop,
   output jsu_pkg::beat_type  beat
);

   logic [1:0] idx_ff, idx_in;
   logic       final_beat;

   always_comb begin
      final_beat = head.status || (idx_ff == 2'(head.num_bytes - 2'd1));
      case (idx_ff)
         2'd0:    beat.out_byte = head.byte0;
         2'd1:    beat.out_byte = head.byte1;
         2'd2:    beat.out_byte = head.byte2;
         default: beat.out_byte = 8'd0;
      endcase
      beat.byte_valid = !head.status;
      beat.error = head.status;
      beat.run_last = final_beat;
      beat.string_end = final_beat && head.last;
      beat.byte_count = head.status ? head.base_count :
                        16'(head.base_count + {14'd0, idx_ff} + 16'd1);
      head_pop = pop && !head_empty && final_beat;
      idx_in = idx_ff;
      if (pop && !head_empty) begin
         idx_in = final_beat ? 2'd0 : 2'(idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

/* rtl/core/json_string_unescape_utf8.sv */
// Top level: JSON string unescape to UTF-8 with the limit register port.
// An input byte is taken every cycle while the entry queue has room.
// Its first result is registered in the entry queue and shown at its head; an escape that
// expands to two or three bytes holds the back end for as many beats.
// Output runs at one beat per cycle while pop is held, so sustained input rate is set by it.
// Synchronous reset clears decode state and the queue; out_limit returns to 65535.
module json_string_unescape_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_error,
   output logic        rsp_run_last,
   output logic        rsp_string_end,
   output logic [15:0] rsp_byte_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0]        limit_ff, limit_in;
   logic               reg_idx;
   logic               entry_valid;
   jsu_pkg::entry_type entry;
   jsu_pkg::entry_type head;
   logic               head_pop;
   jsu_pkg::beat_type  beat;

   assign pready = 1'b1;
   assign reg_idx = paddr[2];
   assign prdata = (reg_idx == jsu_pkg::REG_OUT_LIMIT) ? {16'd0, limit_ff} : 32'd0;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && reg_idx == jsu_pkg::REG_OUT_LIMIT) begin
         limit_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= jsu_pkg::OUT_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_full  (full),
      .in_byte     (req_in_byte),
      .last_byte   (req_last_byte),
      .out_limit   (limit_ff),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_valid),
      .wr_entry (entry),
      .rd_en    (head_pop),
      .rd_entry (head),
      .full     (full),
      .empty    (empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (empty),
      .pop        (pop),
      .head_pop   (head_pop),
      .beat       (beat)
   );

   assign rsp_out_byte = beat.out_byte;
   assign rsp_byte_valid = beat.byte_valid;
   assign rsp_error = beat.error;
   assign rsp_run_last = beat.run_last;
   assign rsp_string_end = beat.string_end;
   assign rsp_byte_count = beat.byte_count;

endmodule
